// ===== sv/sync_word_frame_aligner_assert.svh =====
// Assertion macros for the frame aligner.
`ifndef SYNC_WORD_FRAME_ALIGNER_ASSERT_SVH
`define SYNC_WORD_FRAME_ALIGNER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SWFA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define SWFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/swfa_pkg.sv =====
package swfa_pkg;

   localparam int MAX_FRAME_LEN_DEF = 32;
   localparam int RESULT_CAP        = 32;
   localparam int MIN_LEN           = 4;
   localparam int BYTE_W            = 8;
   localparam int LEN_W             = 6;
   localparam int POS_W             = 5;
   localparam int SYNC_W            = 16;
   localparam int HDR_BYTES         = 2;
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = 16;
   localparam int RSP_DATA_W        = 16;

   localparam logic [SYNC_W-1:0] SYNC_RESET = 16'hAA55;
   localparam logic [LEN_W-1:0]  LEN_RESET  = 6'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_PATTERN = 1'b0,
      CSR_FRAME_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SYNC_W-1:0] sync_pattern;
      logic [LEN_W-1:0]  frame_length;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] hdr0;
      logic [BYTE_W-1:0] hdr1;
      logic [LEN_W-1:0]  len;
   } desc_type;

   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic       valid;
      logic       full;
      logic [1:0] level;
   } q_status_type;

endpackage

// ===== sv/swfa_front.sv =====
module swfa_front #(
   parameter int DEPTH  = swfa_pkg::MAX_FRAME_LEN_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  swfa_pkg::cfg_type            cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [swfa_pkg::BYTE_W-1:0]  req_tdata,
   input  swfa_pkg::q_status_type       q_status,
   output logic                         push,
   output swfa_pkg::desc_type           desc,
   output swfa_pkg::wr_type             wr,
   output logic [ADDR_W-1:0]            wr_addr
);

   localparam int LEN_W  = swfa_pkg::LEN_W;
   localparam int BYTE_W = swfa_pkg::BYTE_W;

   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [BYTE_W-1:0] hdr0_ff, hdr0_in;
   logic [BYTE_W-1:0] hdr1_ff, hdr1_in;
   logic [BYTE_W-1:0] last_ff, last_in;
   logic [LEN_W-1:0]  eff_len;
   logic [LEN_W-1:0]  fill_inc;
   logic [swfa_pkg::SYNC_W-1:0] word;
   logic              accept;
   logic              match;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign word       = {req_tdata, last_ff};
   assign match      = (word == cfg.sync_pattern);
   assign fill_inc   = fill_ff + LEN_W'(1);

   always_comb begin
      if (cfg.frame_length < LEN_W'(swfa_pkg::MIN_LEN)) begin
         eff_len = LEN_W'(swfa_pkg::MIN_LEN);
      end else if (cfg.frame_length > LEN_W'(DEPTH)) begin
         eff_len = LEN_W'(DEPTH);
      end else begin
         eff_len = cfg.frame_length;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      hdr0_in = hdr0_ff;
      hdr1_in = hdr1_ff;
      last_in = last_ff;
      push    = 1'b0;
      wr.en   = 1'b0;
      wr.data = req_tdata;
      if (accept) begin
         last_in = req_tdata;
         if (fill_ff == LEN_W'(0)) begin
            hdr0_in = req_tdata;
            fill_in = LEN_W'(1);
         end else if (fill_ff == LEN_W'(1)) begin
            if (match) begin
               hdr1_in = req_tdata;
               fill_in = LEN_W'(swfa_pkg::HDR_BYTES);
            end else begin
               hdr0_in = req_tdata;
            end
         end else if (match) begin
            hdr0_in = last_ff;
            hdr1_in = req_tdata;
            fill_in = LEN_W'(swfa_pkg::HDR_BYTES);
         end else begin
            wr.en = 1'b1;
            if (fill_inc >= eff_len) begin
               push    = 1'b1;
               fill_in = LEN_W'(0);
            end else begin
               fill_in = fill_inc;
            end
         end
      end
   end

   assign wr_addr   = fill_ff[ADDR_W-1:0];
   assign desc.hdr0 = hdr0_ff;
   assign desc.hdr1 = hdr1_ff;
   assign desc.len  = eff_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr0_ff <= hdr0_in;
      hdr1_ff <= hdr1_in;
      last_ff <= last_in;
   end

endmodule

// ===== sv/swfa_queue.sv =====
module swfa_queue #(
   parameter int ADDR_W = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  swfa_pkg::desc_type           desc_in,
   input  swfa_pkg::wr_type             wr,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic                         pop,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [swfa_pkg::BYTE_W-1:0]  rd_data,
   output swfa_pkg::desc_type           head,
   output swfa_pkg::q_status_type       q_status
);

   localparam int ENTRIES = 2 ** (ADDR_W + 1);

   swfa_pkg::desc_type          desc_ff [2];
   logic [swfa_pkg::BYTE_W-1:0] payload_mem_ff [ENTRIES];
   logic [swfa_pkg::BYTE_W-1:0] rd_data_ff;
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [1:0]                  level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   level_in = level_ff + 2'd1;
         2'b01:   level_in = level_ff - 2'd1;
         default: level_in = level_ff;
      endcase
   end

   assign head           = desc_ff[rd_ptr_ff];
   assign rd_data        = rd_data_ff;
   assign q_status.valid = (level_ff != 2'd0);
   assign q_status.full  = (level_ff == 2'd2);
   assign q_status.level = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         desc_ff[wr_ptr_ff] <= desc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         payload_mem_ff[{wr_ptr_ff, wr_addr}] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= payload_mem_ff[{rd_ptr_ff, rd_addr}];
      end
   end

endmodule

// ===== sv/swfa_back.sv =====
module swfa_back #(
   parameter int ADDR_W = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  swfa_pkg::q_status_type           q_status,
   input  swfa_pkg::desc_type               head,
   input  logic [swfa_pkg::BYTE_W-1:0]      rd_data,
   output logic                             pop,
   output logic                             rd_en,
   output logic [ADDR_W-1:0]                rd_addr,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [swfa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int POS_W  = swfa_pkg::POS_W;
   localparam int BYTE_W = swfa_pkg::BYTE_W;
   localparam int LEN_W  = swfa_pkg::LEN_W;
   localparam int PAD_W  = swfa_pkg::RSP_DATA_W - POS_W - BYTE_W;

   logic [POS_W-1:0]  k_ff, k_in;
   logic              p1_valid_ff, p1_valid_in;
   logic [POS_W-1:0]  p1_pos_ff;
   logic              p1_last_ff;
   logic              p1_hdr_sel_ff;
   logic [BYTE_W-1:0] p1_hdr_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic [POS_W-1:0]  out_pos_ff;
   logic              out_last_ff;
   logic              out_load;
   logic              p1_free;
   logic              issue;
   logic              last_pos;

   assign out_load = !out_valid_ff || rsp_tready;
   assign p1_free  = !p1_valid_ff || out_load;
   assign issue    = q_status.valid && p1_free;
   assign last_pos = ({1'b0, k_ff} == head.len - LEN_W'(1));
   assign pop      = issue && last_pos;
   assign rd_en    = issue;
   assign rd_addr  = k_ff[ADDR_W-1:0];

   always_comb begin
      k_in         = k_ff;
      p1_valid_in  = p1_valid_ff;
      out_valid_in = out_valid_ff;
      if (issue) begin
         k_in = last_pos ? '0 : k_ff + POS_W'(1);
      end
      if (out_load) begin
         out_valid_in = p1_valid_ff;
         p1_valid_in  = 1'b0;
      end
      if (issue) begin
         p1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p1_pos_ff     <= k_ff;
         p1_last_ff    <= last_pos;
         p1_hdr_sel_ff <= (k_ff < POS_W'(swfa_pkg::HDR_BYTES));
         p1_hdr_ff     <= k_ff[0] ? head.hdr1 : head.hdr0;
      end
      if (out_load && p1_valid_ff) begin
         out_byte_ff <= p1_hdr_sel_ff ? p1_hdr_ff : rd_data;
         out_pos_ff  <= p1_pos_ff;
         out_last_ff <= p1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_pos_ff, out_byte_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/sync_word_frame_aligner.sv =====
// A frame drains while the next fills, via the frame queue, p1 stage and output register.
// Throughput: one byte a cycle in, one beat a cycle out while rsp_tready is high.
// The input stalls only while two finished frames wait in the two-slot frame queue.
// Reset is synchronous, active high: clears fill count, queue and output valid,
// sets sync_pattern to 0xAA55 and frame_length to 32; the frame buffer is not cleared.
`include "sync_word_frame_aligner_assert.svh"

module sync_word_frame_aligner #(
   parameter int MAX_FRAME_LEN = swfa_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [swfa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [swfa_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [swfa_pkg::BYTE_W-1:0]           req_tdata,   // rx_byte[7:0]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [swfa_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // frame_byte[7:0], byte_position[12:8]
   output logic                                  rsp_tlast
);

   localparam int DEPTH  = (MAX_FRAME_LEN < swfa_pkg::RESULT_CAP) ? MAX_FRAME_LEN
                                                                  : swfa_pkg::RESULT_CAP;
   localparam int ADDR_W = $clog2(DEPTH);

   swfa_pkg::cfg_type       cfg_ff, cfg_in;
   swfa_pkg::desc_type      desc;
   swfa_pkg::desc_type      head;
   swfa_pkg::wr_type        wr;
   swfa_pkg::q_status_type  q_status;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ADDR_W-1:0]       rd_addr;
   logic [swfa_pkg::BYTE_W-1:0] rd_data;
   logic                    q_push;
   logic                    q_pop;
   logic                    rd_en;
   logic [1:0]              q_level;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (swfa_pkg::csr_index_type'(csr_index))
            swfa_pkg::CSR_SYNC_PATTERN: cfg_in.sync_pattern = csr_wdata;
            swfa_pkg::CSR_FRAME_LENGTH: cfg_in.frame_length = csr_wdata[swfa_pkg::LEN_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_pattern <= swfa_pkg::SYNC_RESET;
         cfg_ff.frame_length <= swfa_pkg::LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swfa_front #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (q_push),
      .desc       (desc),
      .wr         (wr),
      .wr_addr    (wr_addr)
   );

   swfa_queue #(
      .ADDR_W (ADDR_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .desc_in  (desc),
      .wr       (wr),
      .wr_addr  (wr_addr),
      .pop      (q_pop),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .head     (head),
      .q_status (q_status)
   );

   swfa_back #(
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head       (head),
      .rd_data    (rd_data),
      .pop        (q_pop),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   assign q_level = q_status.level;

   `SWFA_ASSERT_IMPLIES(a_push_not_full, clock, reset, q_push, q_level != 2'd2, "frame pushed into full queue")
   `SWFA_ASSERT_IMPLIES(a_pop_not_empty, clock, reset, q_pop, q_level != 2'd0, "frame popped from empty queue")
   `SWFA_ASSERT_NEXT(a_pos_advance, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, !rsp_tvalid || (rsp_tdata[12:8] == 5'($past(rsp_tdata[12:8]) + 5'd1)), "byte position skipped within frame")

endmodule
